FILE: rtl/csr_sparse_matvec_unit_defines.svh
// Assertion macros used by the checker file of the sparse mat-vec unit.
`ifndef CSR_SPARSE_MATVEC_UNIT_DEFINES_SVH
`define CSR_SPARSE_MATVEC_UNIT_DEFINES_SVH

// Same-cycle implication, disabled while reset is asserted.
`define CSM_ASSERT_NOW(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error("csm check failed");

// Next-cycle implication, disabled while reset is asserted.
`define CSM_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error("csm check failed");

`endif

FILE: rtl/csm_pkg.sv
// Types and constants of the sparse matrix-vector unit.
`timescale 1ns / 1ps
package csm_pkg;

    localparam int VECTOR_DEPTH = 1024;
    localparam int VALUE_WIDTH  = 32;
    localparam int FRAC_BITS    = 16;
    localparam int ACC_W        = 48;
    localparam int PROD_W       = 2 * VALUE_WIDTH;
    localparam int IDX_W        = $clog2(VECTOR_DEPTH);
    localparam int COL_W        = 11;
    localparam int ROW_W        = 16;
    localparam int CFG_DATA_W   = 16;

    // Output queue sizing: pipeline holds at most PIPE_DEPTH beats in flight.
    localparam int FIFO_DEPTH   = 8;
    localparam int FIFO_AW      = $clog2(FIFO_DEPTH);
    localparam int PIPE_DEPTH   = 3;

    typedef enum logic [1:0] {
        OP_LOAD  = 2'd0,
        OP_ENTRY = 2'd1,
        OP_EMPTY = 2'd2
    } t_op;

    typedef enum logic {
        CFG_NUM_COLS = 1'b0,
        CFG_NUM_ROWS = 1'b1
    } t_cfg_reg;

    // One accepted beat headed into the MAC pipeline.
    typedef struct packed {
        logic                          entry;
        logic                          empty;
        logic                          bad;
        logic                          row_end;
        logic signed [VALUE_WIDTH-1:0] value;
    } t_beat;

    typedef struct packed {
        logic signed [VALUE_WIDTH-1:0] row_sum;
        logic [ROW_W-1:0]              row_number;
        logic                          last_row;
        logic                          saturated;
        logic                          column_error;
    } t_result;

endpackage

FILE: rtl/csm_vec_store.sv
// Dense vector store: one write port, one registered read port.
`timescale 1ns / 1ps
module csm_vec_store (
    input  logic                                    i_clk,
    input  logic                                    i_wr_en,
    input  logic [csm_pkg::IDX_W-1:0]               i_wr_addr,
    input  logic signed [csm_pkg::VALUE_WIDTH-1:0]  i_wr_data,
    input  logic                                    i_rd_en,
    input  logic [csm_pkg::IDX_W-1:0]               i_rd_addr,
    output logic signed [csm_pkg::VALUE_WIDTH-1:0]  o_rd_data
);

    logic signed [csm_pkg::VALUE_WIDTH-1:0] r_mem [csm_pkg::VECTOR_DEPTH];
    logic signed [csm_pkg::VALUE_WIDTH-1:0] r_rd_data;

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_rd_en) begin
            r_rd_data <= r_mem[i_rd_addr];
        end
    end

    assign o_rd_data = r_rd_data;

endmodule

FILE: rtl/csm_mac.sv
// Multiply-accumulate pipeline, row close, saturation and row counting.
`timescale 1ns / 1ps
module csm_mac (
    input  logic                                    i_clk,
    input  logic                                    i_rst_n,
    input  csm_pkg::t_beat                          i_beat,
    input  logic signed [csm_pkg::VALUE_WIDTH-1:0]  i_rd_data,
    input  logic [csm_pkg::ROW_W-1:0]               i_num_rows,
    output logic                                    o_res_valid,
    output csm_pkg::t_result                        o_res
);

    localparam int AW = csm_pkg::ACC_W;
    localparam int VW = csm_pkg::VALUE_WIDTH;
    localparam logic signed [AW-1:0] ACC_MAX = {1'b0, {(AW-1){1'b1}}};
    localparam logic signed [AW-1:0] ACC_MIN = {1'b1, {(AW-1){1'b0}}};
    localparam logic signed [VW-1:0] VAL_MAX = {1'b0, {(VW-1){1'b1}}};
    localparam logic signed [VW-1:0] VAL_MIN = {1'b1, {(VW-1){1'b0}}};

    // stage 1: store read in flight
    csm_pkg::t_beat r_s1;

    // stage 2: product
    logic                                r_s2_vld;
    logic                                r_s2_add;
    logic                                r_s2_bad;
    logic                                r_s2_close;
    logic signed [csm_pkg::PROD_W-1:0]   r_s2_prod;

    // running row state
    logic signed [AW-1:0]                r_acc;
    logic                                r_err;

    // stage 3: closed row
    logic                                r_s3_vld;
    logic signed [AW-1:0]                r_s3_acc;
    logic                                r_s3_err;
    logic [csm_pkg::ROW_W-1:0]           r_row_cnt;

    logic signed [AW-1:0]                w_p;
    logic signed [AW:0]                  w_sum;
    logic signed [AW-1:0]                w_acc_add;
    logic signed [AW-1:0]                w_acc_upd;
    logic                                w_err_upd;
    logic                                w_fits;
    logic                                w_last;
    logic [csm_pkg::ROW_W-1:0]           w_last_idx;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1.entry <= 1'b0;
            r_s1.empty <= 1'b0;
        end else begin
            r_s1.entry <= i_beat.entry;
            r_s1.empty <= i_beat.empty;
        end
        r_s1.bad     <= i_beat.bad;
        r_s1.row_end <= i_beat.row_end;
        r_s1.value   <= i_beat.value;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s2_vld <= 1'b0;
        end else begin
            r_s2_vld <= r_s1.entry | r_s1.empty;
        end
        r_s2_add   <= r_s1.entry & ~r_s1.bad;
        r_s2_bad   <= r_s1.entry & r_s1.bad;
        r_s2_close <= r_s1.empty | r_s1.row_end;
        r_s2_prod  <= r_s1.value * i_rd_data;
    end

    // arithmetic shift right is the floor of the Q16.16 product
    assign w_p       = r_s2_prod[csm_pkg::PROD_W-1:csm_pkg::FRAC_BITS];
    assign w_sum     = {r_acc[AW-1], r_acc} + {w_p[AW-1], w_p};
    assign w_acc_add = (w_sum[AW] != w_sum[AW-1]) ? (w_sum[AW] ? ACC_MIN : ACC_MAX)
                                                   : w_sum[AW-1:0];
    assign w_acc_upd = r_s2_add ? w_acc_add : r_acc;
    assign w_err_upd = r_err | r_s2_bad;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_acc    <= '0;
            r_err    <= 1'b0;
            r_s3_vld <= 1'b0;
        end else begin
            r_s3_vld <= r_s2_vld & r_s2_close;
            if (r_s2_vld) begin
                if (r_s2_close) begin
                    r_acc <= '0;
                    r_err <= 1'b0;
                end else begin
                    r_acc <= w_acc_upd;
                    r_err <= w_err_upd;
                end
            end
        end
        r_s3_acc <= w_acc_upd;
        r_s3_err <= w_err_upd;
    end

    // the sum fits when all bits above the value's sign bit match it
    assign w_fits     = (&r_s3_acc[AW-1:VW-1]) | ~(|r_s3_acc[AW-1:VW-1]);
    assign w_last_idx = i_num_rows - 1'b1;
    assign w_last     = (r_row_cnt == w_last_idx);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_row_cnt <= '0;
        end else if (r_s3_vld) begin
            r_row_cnt <= w_last ? '0 : r_row_cnt + 1'b1;
        end
    end

    always_comb begin
        o_res_valid        = r_s3_vld;
        o_res.row_sum      = w_fits ? r_s3_acc[VW-1:0] : (r_s3_acc[AW-1] ? VAL_MIN : VAL_MAX);
        o_res.row_number   = r_row_cnt;
        o_res.last_row     = w_last;
        o_res.saturated    = ~w_fits;
        o_res.column_error = r_s3_err;
    end

endmodule

FILE: rtl/csm_out_fifo.sv
// Result queue between the MAC pipeline and the output channel.
`timescale 1ns / 1ps
module csm_out_fifo (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_wr_en,
    input  csm_pkg::t_result              i_wr_data,
    input  logic                          i_rd_en,
    output logic                          o_not_empty,
    output csm_pkg::t_result              o_rd_data,
    output logic [csm_pkg::FIFO_AW:0]     o_count
);

    csm_pkg::t_result                  r_mem [csm_pkg::FIFO_DEPTH];
    logic [csm_pkg::FIFO_AW-1:0]       r_wr_ptr;
    logic [csm_pkg::FIFO_AW-1:0]       r_rd_ptr;
    logic [csm_pkg::FIFO_AW:0]         r_count;
    logic [csm_pkg::FIFO_AW:0]         n_count;

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[r_wr_ptr] <= i_wr_data;
        end
    end

    always_comb begin
        n_count = r_count;
        case ({i_wr_en, i_rd_en})
            2'b10:   n_count = r_count + 1'b1;
            2'b01:   n_count = r_count - 1'b1;
            default: n_count = r_count;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (i_wr_en) begin
                r_wr_ptr <= r_wr_ptr + 1'b1;
            end
            if (i_rd_en) begin
                r_rd_ptr <= r_rd_ptr + 1'b1;
            end
            r_count <= n_count;
        end
    end

    assign o_not_empty = (r_count != '0);
    assign o_rd_data   = r_mem[r_rd_ptr];
    assign o_count     = r_count;

endmodule

FILE: rtl/csr_sparse_matvec_unit.sv
// A row-closing beat passes stage 1, stage 2 and stage 3 before its result is written to the queue.
// Throughput: one beat per cycle while o_in_stall is low, set by the single MAC and the store's one read port.
// Input stalls only while the result queue holds 5 or more unread rows.
// Reset (sync, active low) clears pipeline valids, accumulator, row counter, queue
// and sets num_cols 1024, num_rows 65535; the vector store is not cleared.
`timescale 1ns / 1ps
module csr_sparse_matvec_unit (
    input  logic                                    i_clk,
    input  logic                                    i_rst_n,
    input  logic                                    i_in_valid,
    output logic                                    o_in_stall,
    input  logic [1:0]                              i_operation,
    input  logic [9:0]                              i_index,
    input  logic signed [31:0]                      i_value,
    input  logic                                    i_row_end,
    output logic                                    o_out_valid,
    input  logic                                    i_out_stall,
    output logic signed [31:0]                      o_row_sum,
    output logic [15:0]                             o_row_number,
    output logic                                    o_last_row,
    output logic                                    o_saturated,
    output logic                                    o_column_error,
    input  logic                                    i_cfg_valid,
    output logic                                    o_cfg_ready,
    input  logic                                    i_cfg_index,
    input  logic [csm_pkg::CFG_DATA_W-1:0]          i_cfg_data
);

    logic [csm_pkg::COL_W-1:0]               r_num_cols;
    logic [csm_pkg::ROW_W-1:0]               r_num_rows;

    logic                                    w_in_acc;
    logic                                    w_is_load;
    logic                                    w_is_entry;
    logic                                    w_is_empty;
    logic                                    w_col_ok;
    csm_pkg::t_beat                          w_beat;
    logic signed [csm_pkg::VALUE_WIDTH-1:0]  w_rd_data;
    logic                                    w_res_valid;
    csm_pkg::t_result                        w_res;
    csm_pkg::t_result                        w_head;
    logic [csm_pkg::FIFO_AW:0]               w_count;
    logic                                    w_out_acc;

    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_num_cols <= csm_pkg::COL_W'(1024);
            r_num_rows <= csm_pkg::ROW_W'(65535);
        end else if (i_cfg_valid && o_cfg_ready) begin
            unique case (csm_pkg::t_cfg_reg'(i_cfg_index))
                csm_pkg::CFG_NUM_COLS: r_num_cols <= i_cfg_data[csm_pkg::COL_W-1:0];
                csm_pkg::CFG_NUM_ROWS: r_num_rows <= i_cfg_data[csm_pkg::ROW_W-1:0];
                default:               r_num_rows <= r_num_rows;
            endcase
        end
    end

    // room for every beat already in the pipeline plus this one
    assign o_in_stall = (w_count >= (csm_pkg::FIFO_AW+1)'(csm_pkg::FIFO_DEPTH
                                                           - csm_pkg::PIPE_DEPTH));
    assign w_in_acc   = i_in_valid & ~o_in_stall;

    always_comb begin
        w_is_load  = 1'b0;
        w_is_entry = 1'b0;
        w_is_empty = 1'b0;
        unique case (csm_pkg::t_op'(i_operation))
            csm_pkg::OP_LOAD:  w_is_load  = 1'b1;
            csm_pkg::OP_ENTRY: w_is_entry = 1'b1;
            csm_pkg::OP_EMPTY: w_is_empty = 1'b1;
            default: begin
                w_is_load  = 1'b0;
                w_is_entry = 1'b0;
                w_is_empty = 1'b0;
            end
        endcase
    end

    assign w_col_ok = (32'(i_index) < 32'(r_num_cols))
                    && (32'(i_index) < csm_pkg::VECTOR_DEPTH);

    always_comb begin
        w_beat.entry   = w_in_acc & w_is_entry;
        w_beat.empty   = w_in_acc & w_is_empty;
        w_beat.bad     = ~w_col_ok;
        w_beat.row_end = i_row_end;
        w_beat.value   = i_value;
    end

    csm_vec_store u_store (
        .i_clk     (i_clk),
        .i_wr_en   (w_in_acc & w_is_load
                    & (32'(i_index) < csm_pkg::VECTOR_DEPTH)),
        .i_wr_addr (i_index[csm_pkg::IDX_W-1:0]),
        .i_wr_data (i_value),
        .i_rd_en   (w_in_acc & w_is_entry),
        .i_rd_addr (i_index[csm_pkg::IDX_W-1:0]),
        .o_rd_data (w_rd_data)
    );

    csm_mac u_mac (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_beat      (w_beat),
        .i_rd_data   (w_rd_data),
        .i_num_rows  (r_num_rows),
        .o_res_valid (w_res_valid),
        .o_res       (w_res)
    );

    assign w_out_acc = o_out_valid & ~i_out_stall;

    csm_out_fifo u_fifo (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_wr_en     (w_res_valid),
        .i_wr_data   (w_res),
        .i_rd_en     (w_out_acc),
        .o_not_empty (o_out_valid),
        .o_rd_data   (w_head),
        .o_count     (w_count)
    );

    assign o_row_sum      = w_head.row_sum;
    assign o_row_number   = w_head.row_number;
    assign o_last_row     = w_head.last_row;
    assign o_saturated    = w_head.saturated;
    assign o_column_error = w_head.column_error;

endmodule

FILE: rtl/csm_checker.sv
// Port-level checks for the sparse mat-vec unit, bound to the top level.
`timescale 1ns / 1ps
`include "csr_sparse_matvec_unit_defines.svh"
module csm_checker (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               o_in_stall,
    input  logic               o_out_valid,
    input  logic               i_out_stall,
    input  logic signed [31:0] o_row_sum,
    input  logic               o_saturated
);

    // a stalled result beat stays offered
    `CSM_ASSERT_NEXT(a_out_hold, i_clk, i_rst_n, o_out_valid && i_out_stall, o_out_valid)

    // input back-pressure only comes from queued results
    `CSM_ASSERT_NOW(a_stall_has_data, i_clk, i_rst_n, o_in_stall, o_out_valid)

    // a clipped sum sits at one of the two bounds
    `CSM_ASSERT_NOW(a_sat_bound, i_clk, i_rst_n, o_out_valid && o_saturated, o_row_sum == 32'sh7fffffff || o_row_sum == 32'sh80000000)

    // the first cycle out of reset shows an empty, unstalled block
    `CSM_ASSERT_NOW(a_reset_clean, i_clk, i_rst_n, !$past(i_rst_n), !o_out_valid && !o_in_stall)

endmodule

bind csr_sparse_matvec_unit csm_checker u_csm_checker (.*);
